// ----- rtl/axf_pkg.sv -----
package axf_pkg;

    // Field widths
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned OP_W     = 4;
    localparam int unsigned SIZE_W   = 2;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned BITS_W   = 6;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADD = 4'd0;
    localparam logic [OP_W-1:0] OP_ADC = 4'd1;
    localparam logic [OP_W-1:0] OP_SUB = 4'd2;
    localparam logic [OP_W-1:0] OP_SBB = 4'd3;
    localparam logic [OP_W-1:0] OP_AND = 4'd4;
    localparam logic [OP_W-1:0] OP_OR  = 4'd5;
    localparam logic [OP_W-1:0] OP_XOR = 4'd6;
    localparam logic [OP_W-1:0] OP_SHL = 4'd7;
    localparam logic [OP_W-1:0] OP_SHR = 4'd8;

    // Operand size codes; any other code means 32 bits
    localparam logic [SIZE_W-1:0] SIZE_8  = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_16 = 2'd1;

    localparam logic [DATA_W-1:0] MASK_8  = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] MASK_16 = 32'h0000_FFFF;
    localparam logic [DATA_W-1:0] MASK_32 = 32'hFFFF_FFFF;

    // Status flags
    typedef struct packed {
        logic cf;
        logic zf;
        logic sf;
        logic pf;
        logic of;
    } flags_t;

endpackage

// ----- rtl/axf_alu.sv -----
module axf_alu
    import axf_pkg::*;
(
    input  logic [OP_W-1:0]   opcode,
    input  logic [DATA_W-1:0] source_operand,
    input  logic [DATA_W-1:0] dest_operand,
    input  logic [SIZE_W-1:0] size_code,
    input  flags_t            flags_in,
    output logic [DATA_W-1:0] result_value,
    output flags_t            flags_out
);

    logic [BITS_W-1:0]  bits;
    logic [COUNT_W-1:0] top;
    logic [DATA_W-1:0]  mask;
    logic [DATA_W-1:0]  src_m;
    logic [DATA_W-1:0]  dst_m;
    logic [COUNT_W-1:0] cnt;
    logic               cin;
    logic [DATA_W:0]    sum;
    logic [DATA_W:0]    diff;
    logic [DATA_W-1:0]  add_res;
    logic [DATA_W-1:0]  sub_res;
    logic [DATA_W-1:0]  shl_res;
    logic [DATA_W-1:0]  shr_res;
    logic [DATA_W-1:0]  add_ovf_vec;
    logic [DATA_W-1:0]  sub_ovf_vec;
    logic [BITS_W-1:0]  shl_idx;
    logic               shl_cf;
    logic               shr_cf;
    logic [DATA_W-1:0]  res;
    logic               zsp_upd;

    // Decode operand size
    always_comb
    begin
        unique case (size_code)
            SIZE_8:
            begin
                bits = 6'd8;
                mask = MASK_8;
            end
            SIZE_16:
            begin
                bits = 6'd16;
                mask = MASK_16;
            end
            default:
            begin
                bits = 6'd32;
                mask = MASK_32;
            end
        endcase
    end

    assign top   = COUNT_W'(bits - 6'd1);
    assign src_m = source_operand & mask;
    assign dst_m = dest_operand & mask;
    assign cnt   = source_operand[COUNT_W-1:0];
    assign cin   = flags_in.cf;

    // Add and subtract with optional kept carry
    assign sum  = {1'b0, dst_m} + {1'b0, src_m}
                + {{DATA_W{1'b0}}, (opcode == OP_ADC) & cin};
    assign diff = {1'b0, dst_m} - {1'b0, src_m}
                - {{DATA_W{1'b0}}, (opcode == OP_SBB) & cin};
    assign add_res     = sum[DATA_W-1:0] & mask;
    assign sub_res     = diff[DATA_W-1:0] & mask;
    assign add_ovf_vec = ~(dst_m ^ src_m) & (dst_m ^ add_res);
    assign sub_ovf_vec = (dst_m ^ src_m) & (dst_m ^ sub_res);

    // Shifts: carry is the last bit shifted out
    assign shl_res = (dst_m << cnt) & mask;
    assign shr_res = dst_m >> cnt;
    assign shl_idx = bits - {1'b0, cnt};
    assign shl_cf  = ({1'b0, cnt} <= bits) ? dst_m[shl_idx[COUNT_W-1:0]] : 1'b0;
    assign shr_cf  = dst_m[cnt - 5'd1];

    // Select result and new CF/OF
    always_comb
    begin
        res          = '0;
        zsp_upd      = 1'b1;
        flags_out    = flags_in;
        unique case (opcode)
            OP_ADD, OP_ADC:
            begin
                res          = add_res;
                flags_out.cf = sum[bits];
                flags_out.of = add_ovf_vec[top];
            end
            OP_SUB, OP_SBB:
            begin
                res          = sub_res;
                flags_out.cf = diff[DATA_W];
                flags_out.of = sub_ovf_vec[top];
            end
            OP_AND, OP_OR, OP_XOR:
            begin
                if (opcode == OP_AND)
                begin
                    res = dst_m & src_m;
                end
                else if (opcode == OP_OR)
                begin
                    res = dst_m | src_m;
                end
                else
                begin
                    res = dst_m ^ src_m;
                end
                flags_out.cf = 1'b0;
                flags_out.of = 1'b0;
            end
            OP_SHL:
            begin
                res = shl_res;
                if (cnt != '0)
                begin
                    flags_out.cf = shl_cf;
                end
            end
            OP_SHR:
            begin
                res = shr_res;
                if (cnt != '0)
                begin
                    flags_out.cf = shr_cf;
                end
            end
            default:
            begin
                res     = '0;
                zsp_upd = 1'b0;
            end
        endcase

        // Zero, sign and parity from the masked result
        if (zsp_upd)
        begin
            flags_out.zf = (res == '0);
            flags_out.sf = res[top];
            flags_out.pf = ~^res[7:0];
        end
    end

    assign result_value = res;

endmodule

// ----- rtl/x86_alu_with_flags_core.sv -----
// x86-style integer ALU with a kept flag register (CF, ZF, SF, PF, OF). One item
// is accepted per cycle while in_stall is low: the item is captured in an input
// register, passes the adder, logic unit, barrel shifter and flag logic and lands
// in the result register, at which edge the kept flags are updated so that an adc
// or sbb in the very next item sees the new carry. A finished result waiting under
// stall does not block the input register from taking one more item; in_stall
// rises only when both registers are full and the output is stalled.
module x86_alu_with_flags_core
    import axf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   opcode,
    input  logic [DATA_W-1:0] source_operand,
    input  logic [DATA_W-1:0] dest_operand,
    input  logic [SIZE_W-1:0] size_code,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] result_value,
    output logic              carry_out,
    output logic              zero_out,
    output logic              sign_out,
    output logic              parity_out,
    output logic              overflow_out
);

    logic              in_valid_reg;
    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] src_reg;
    logic [DATA_W-1:0] dst_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              res_valid_reg;
    logic [DATA_W-1:0] res_reg;
    flags_t            res_flags_reg;
    flags_t            flags_reg;
    flags_t            flags_next;
    logic [DATA_W-1:0] alu_res;
    logic              res_free;
    logic              advance;
    logic              accept;

    assign res_free = ~res_valid_reg | ~out_stall;
    assign advance  = in_valid_reg & res_free;
    assign in_stall = in_valid_reg & ~res_free;
    assign accept   = in_valid & ~in_stall;

    // Hold the incoming item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            src_reg  <= source_operand;
            dst_reg  <= dest_operand;
            size_reg <= size_code;
        end
    end

    axf_alu u_alu (
        .opcode         (op_reg),
        .source_operand (src_reg),
        .dest_operand   (dst_reg),
        .size_code      (size_reg),
        .flags_in       (flags_reg),
        .result_value   (alu_res),
        .flags_out      (flags_next)
    );

    // Advance into the result register and update the kept flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg       <= alu_res;
            res_flags_reg <= flags_next;
        end
    end

    assign out_valid    = res_valid_reg;
    assign result_value = res_reg;
    assign carry_out    = res_flags_reg.cf;
    assign zero_out     = res_flags_reg.zf;
    assign sign_out     = res_flags_reg.sf;
    assign parity_out   = res_flags_reg.pf;
    assign overflow_out = res_flags_reg.of;

`ifndef SYNTHESIS
    // Kept flags match the flags of the item just delivered
    a_flags_track: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (flags_reg == res_flags_reg))
        else $error("kept flags differ from delivered flags");

    // Logic operations clear CF and OF
    a_logic_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg == OP_AND || op_reg == OP_OR || op_reg == OP_XOR)
        |=> (!carry_out && !overflow_out))
        else $error("logic operation left CF or OF set");

    // Unused opcodes give zero and leave flags alone
    a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg > OP_SHR)
        |=> (result_value == '0) && (flags_reg == $past(flags_reg)))
        else $error("unused opcode changed state");

    // A stalled input item is not lost
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg)
        else $error("input item dropped while stalled");

    // Input stalls only when the result register is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (res_valid_reg && out_stall))
        else $error("input stalled without cause");
`endif

endmodule

// ----- test/alu_check_pkg.sv -----
package alu_check_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import axf_pkg::*;

    // Codes the RTL package leaves unnamed
    localparam logic [SIZE_W-1:0] SIZE_32        = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_SPARE     = 2'd3;
    localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 4'd9;
    localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 4'd15;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        flags_t            flags;
    } alu_result_t;

    class alu_scoreboard;
        flags_t      kept_flags;
        alu_result_t expected_results[$];
        int unsigned error_count;

        function new();
            kept_flags = '0;
            error_count = 0;
        endfunction

        // Work out one item against the kept flags and update them
        function alu_result_t execute(logic [OP_W-1:0] op, logic [DATA_W-1:0] src,
                                      logic [DATA_W-1:0] dst, logic [SIZE_W-1:0] size);
            int unsigned       width;
            int unsigned       top;
            logic [DATA_W-1:0] mask;
            logic [DATA_W-1:0] s;
            logic [DATA_W-1:0] d;
            logic [DATA_W-1:0] res;
            logic [DATA_W-1:0] ovf_bits;
            logic [63:0]       wide;
            logic [63:0]       diff;
            logic [COUNT_W-1:0] count;
            logic              sets_zsp;
            alu_result_t       r;
            case (size)
                SIZE_8:  begin width = 8;  mask = MASK_8;  end
                SIZE_16: begin width = 16; mask = MASK_16; end
                default: begin width = 32; mask = MASK_32; end
            endcase
            s = src & mask;
            d = dst & mask;
            top = width - 1;
            count = src[COUNT_W-1:0];
            res = '0;
            sets_zsp = 1'b1;
            case (op)
                OP_ADD, OP_ADC:
                begin
                    wide = {32'd0, d} + {32'd0, s} + ((op == OP_ADC) ? {63'd0, kept_flags.cf} : 64'd0);
                    res = wide[DATA_W-1:0] & mask;
                    kept_flags.cf = (wide > {32'd0, mask});
                    ovf_bits = ~(d ^ s) & (d ^ res);
                    kept_flags.of = ovf_bits[top];
                end
                OP_SUB, OP_SBB:
                begin
                    wide = {32'd0, s} + ((op == OP_SBB) ? {63'd0, kept_flags.cf} : 64'd0);
                    diff = {32'd0, d} - wide;
                    res = diff[DATA_W-1:0] & mask;
                    kept_flags.cf = ({32'd0, d} < wide);
                    ovf_bits = (d ^ s) & (d ^ res);
                    kept_flags.of = ovf_bits[top];
                end
                OP_AND, OP_OR, OP_XOR:
                begin
                    if (op == OP_AND)
                        res = d & s;
                    else if (op == OP_OR)
                        res = d | s;
                    else
                        res = d ^ s;
                    kept_flags.cf = 1'b0;
                    kept_flags.of = 1'b0;
                end
                OP_SHL:
                begin
                    res = (d << count) & mask;
                    // last bit out; past the operand it is zero
                    if (count != 0)
                        kept_flags.cf = (count <= width) ? d[width - count] : 1'b0;
                end
                OP_SHR:
                begin
                    res = d >> count;
                    if (count != 0)
                        kept_flags.cf = (count <= width) ? d[count - 1] : 1'b0;
                end
                default:
                begin
                    // spare opcodes give zero and leave the kept flags as they are
                    sets_zsp = 1'b0;
                end
            endcase
            if (sets_zsp)
            begin
                kept_flags.zf = (res == '0);
                kept_flags.sf = res[top];
                kept_flags.pf = ~^res[7:0];
            end
            r.value = res;
            r.flags = kept_flags;
            return r;
        endfunction

        // Note an accepted item
        function void note_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] src,
                                logic [DATA_W-1:0] dst, logic [SIZE_W-1:0] size);
            expected_results.push_back(execute(op, src, dst, size));
        endfunction

        function void compare_flag(string name, logic exp_bit, logic act_bit);
            if (act_bit !== exp_bit)
            begin
                $display("%0t ns: %s mismatch: expected %b, actual %b", $time, name, exp_bit, act_bit);
                error_count++;
            end
        endfunction

        // Check an accepted result against the oldest expectation
        function void check_result(alu_result_t actual);
            alu_result_t exp_r;
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: unexpected result: expected none, actual %h", $time, actual.value);
                error_count++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (actual.value !== exp_r.value)
            begin
                $display("%0t ns: result_value mismatch: expected %h, actual %h",
                         $time, exp_r.value, actual.value);
                error_count++;
            end
            compare_flag("carry_out", exp_r.flags.cf, actual.flags.cf);
            compare_flag("zero_out", exp_r.flags.zf, actual.flags.zf);
            compare_flag("sign_out", exp_r.flags.sf, actual.flags.sf);
            compare_flag("parity_out", exp_r.flags.pf, actual.flags.pf);
            compare_flag("overflow_out", exp_r.flags.of, actual.flags.of);
        endfunction
    endclass

endpackage

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import axf_pkg::*;
    import alu_check_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1150;
    localparam int unsigned QUIET_TAIL   = 150;
    localparam int unsigned DRAIN_ITEM   = 500;
    localparam int unsigned STALL_LIMIT  = 1000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   opcode = OP_ADD;
    logic [DATA_W-1:0] source_operand = '0;
    logic [DATA_W-1:0] dest_operand = '0;
    logic [SIZE_W-1:0] size_code = SIZE_8;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] result_value;
    logic              carry_out;
    logic              zero_out;
    logic              sign_out;
    logic              parity_out;
    logic              overflow_out;

    alu_scoreboard sb;
    int unsigned   idle_pct = 0;
    int unsigned   stall_pct = 0;
    int unsigned   stall_left = 0;
    int unsigned   quiet_cycles = 0;

    x86_alu_with_flags_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .source_operand (source_operand),
        .dest_operand   (dest_operand),
        .size_code      (size_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_value   (result_value),
        .carry_out      (carry_out),
        .zero_out       (zero_out),
        .sign_out       (sign_out),
        .parity_out     (parity_out),
        .overflow_out   (overflow_out)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Stall the result side in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Check each accepted result
    always @(posedge clk)
    begin
        alu_result_t actual;
        if (rst_n && out_valid && !out_stall)
        begin
            actual.value = result_value;
            actual.flags = '{cf: carry_out, zf: zero_out, sf: sign_out,
                             pf: parity_out, of: overflow_out};
            sb.check_result(actual);
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item, with an optional idle burst first, and hold it until taken
    task automatic send_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] src,
                             logic [DATA_W-1:0] dst, logic [SIZE_W-1:0] size);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        source_operand <= src;
        dest_operand <= dst;
        size_code <= size;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_item(op, src, dst, size);
    endtask

    // Operand mix: extremes, sign boundaries, small values and random words
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] edges [6];
        edges = '{32'h0000_007F, 32'h0000_0080, 32'h0000_7FFF,
                  32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return MASK_32;
            2: return edges[$urandom_range(0, 5)];
            3: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_shift_source();
        logic [COUNT_W-1:0] counts [9];
        logic [DATA_W-1:0]  word;
        counts = '{5'd0, 5'd1, 5'd7, 5'd8, 5'd9, 5'd15, 5'd16, 5'd17, 5'd31};
        word = $urandom;
        if ($urandom_range(0, 1) == 0)
            word[COUNT_W-1:0] = counts[$urandom_range(0, 8)];
        return word;
    endfunction

    initial
    begin
        logic [OP_W-1:0]   op;
        logic [OP_W-1:0]   chain_op;
        logic [DATA_W-1:0] src;
        int unsigned       chain_left;

        sb = new();
        chain_left = 0;
        chain_op = OP_ADC;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: carries, overflow, borrows, logic ops, shift edges, spare codes
        send_item(OP_ADD, 32'h0000_0001, 32'h0000_00FF, SIZE_8);
        send_item(OP_ADC, 32'h0000_0000, 32'h0000_0000, SIZE_8);
        send_item(OP_ADD, 32'h0000_0001, 32'h0000_007F, SIZE_8);
        send_item(OP_ADD, 32'h0000_0001, 32'h0000_FFFF, SIZE_16);
        send_item(OP_ADD, MASK_32, MASK_32, SIZE_32);
        send_item(OP_ADC, 32'h0000_0000, 32'h7FFF_FFFF, SIZE_32);
        send_item(OP_SUB, 32'h0000_0001, 32'h0000_0000, SIZE_32);
        send_item(OP_SBB, MASK_32, 32'h0000_0000, SIZE_32);
        send_item(OP_SUB, 32'h0000_0001, 32'h0000_8000, SIZE_16);
        send_item(OP_SBB, 32'h0000_0000, 32'h0000_0080, SIZE_8);
        send_item(OP_AND, 32'h0000_0000, MASK_32, SIZE_SPARE);
        send_item(OP_OR, 32'h8000_0000, 32'h0000_0000, SIZE_SPARE);
        send_item(OP_XOR, MASK_32, 32'hA5A5_A5A5, SIZE_16);
        send_item(OP_SUB, 32'h0000_0001, 32'h0000_0000, SIZE_8);
        send_item(OP_SHL, 32'hFFFF_FFE0, 32'h0000_0080, SIZE_8);
        send_item(OP_SHL, 32'h0000_0001, 32'h0000_0080, SIZE_8);
        send_item(OP_SHL, 32'h0000_0008, 32'h0000_0001, SIZE_8);
        send_item(OP_SHL, 32'h0000_0009, 32'h0000_00FF, SIZE_8);
        send_item(OP_SHR, 32'h0000_0000, 32'h0000_8001, SIZE_16);
        send_item(OP_SHR, 32'h0000_0001, 32'h0000_0001, SIZE_16);
        send_item(OP_SHR, 32'h0000_0010, 32'h0000_8000, SIZE_16);
        send_item(OP_SHR, 32'h0000_001F, MASK_32, SIZE_32);
        send_item(OP_SHL, 32'h0000_001F, 32'h0000_0001, SIZE_32);
        send_item(OP_SPARE_FIRST, MASK_32, MASK_32, SIZE_32);
        send_item(OP_SPARE_LAST, MASK_32, MASK_32, SIZE_SPARE);

        // Random items; idling and stalling change every 200 items and stop for the tail
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            else if (i % 200 == 0)
            begin
                idle_pct = (i % 400 == 0) ? 25 : $urandom_range(0, 40);
                stall_pct = (i == 200) ? 0 : $urandom_range(5, 40);
            end

            // Hold off until every outstanding result is back
            if (i == DRAIN_ITEM)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.expected_results.size() != 0)
                    @(posedge clk);
            end

            // Multi-word add and subtract chains carry through adc and sbb
            if (chain_left != 0)
            begin
                op = chain_op;
                chain_left--;
            end
            else if ($urandom_range(0, 15) == 0)
                op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            else
            begin
                op = OP_W'($urandom_range(OP_ADD, OP_SHR));
                if ((op == OP_ADD || op == OP_SUB) && $urandom_range(0, 3) == 0)
                begin
                    chain_op = (op == OP_ADD) ? OP_ADC : OP_SBB;
                    chain_left = $urandom_range(1, 3);
                end
            end

            src = (op == OP_SHL || op == OP_SHR) ? pick_shift_source() : pick_operand();
            send_item(op, src, pick_operand(), SIZE_W'($urandom_range(0, 3)));
        end
        in_valid <= 1'b0;

        // Drain the outstanding results, then allow for the pipeline depth
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- x86_alu_with_flags_core.f -----
rtl/axf_pkg.sv
rtl/axf_alu.sv
rtl/x86_alu_with_flags_core.sv
test/alu_check_pkg.sv
test/testbench.sv
